FILE: sv/knn_pkg.sv
// knn_pkg: types, register codes and the ordering function shared by the
// k-nearest-neighbour selection block. No dependencies.
package knn_pkg;

   localparam int LOC_WIDTH  = 10;
   localparam int DIST_WIDTH = 32;
   localparam int CNT_WIDTH  = 6;

   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 10;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEPOT_COUNT     = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NEIGHBOUR_COUNT = 4'd1;

   localparam logic [LOC_WIDTH-1:0] DEPOT_COUNT_RESET     = 10'd1;
   localparam logic [CNT_WIDTH-1:0] NEIGHBOUR_COUNT_RESET = 6'd40;

   typedef struct packed {
      logic [LOC_WIDTH-1:0]  row_location;
      logic [LOC_WIDTH-1:0]  column_location;
      logic [DIST_WIDTH-1:0] distance;
      logic                  last_in_row;
   } req_type;

   typedef struct packed {
      logic [LOC_WIDTH-1:0]  neighbour_location;
      logic [DIST_WIDTH-1:0] neighbour_distance;
      logic                  last_neighbour;
   } rsp_type;

   // one kept neighbour
   typedef struct packed {
      logic                  valid;
      logic [DIST_WIDTH-1:0] distance;
      logic [LOC_WIDTH-1:0]  location;
   } entry_type;

   localparam entry_type ENTRY_EMPTY = '{valid: 1'b0, distance: '1, location: '0};

   // controls broadcast to every list cell
   typedef struct packed {
      logic insert;
      logic clear;
      logic in_cap;
   } list_ctl_type;

   // controls broadcast to every drain cell
   typedef struct packed {
      logic load;
      logic pop;
   } drain_ctl_type;

   // true when (d1,l1) orders strictly before (d2,l2)
   function automatic logic orders_first(input logic [DIST_WIDTH-1:0] d1,
                                         input logic [LOC_WIDTH-1:0]  l1,
                                         input logic [DIST_WIDTH-1:0] d2,
                                         input logic [LOC_WIDTH-1:0]  l2);
      return (d1 < d2) || ((d1 == d2) && (l1 < l2));
   endfunction

endpackage

FILE: sv/k_nearest_neighbour_select_top.sv
// k_nearest_neighbour_select_top: keeps the k nearest client columns of a
// streamed distance-matrix row and emits them nearest first at row end.
// Depends on knn_pkg, knn_list_cell and knn_drain_cell.
//
// One matrix entry is taken per cycle while no row end is held off: every
// list cell compares the entry with its own slot at once, so an inserted
// entry is in the list in the next cycle. The entry marked last_in_row hands
// the whole list to a result shift chain and clears the list, so the next
// row starts at once. Results leave one per cycle from the head of that
// chain while rsp_ready is high. A last_in_row request is held off while the
// previous row's results, at most MAX_NEIGHBOURS, are still draining, which
// lasts longer while the receiver holds off; other requests are never held.
// Ties in distance go to the lower column index.
// Configuration writes are always accepted.
module k_nearest_neighbour_select_top import knn_pkg::*; #(
   parameter int MAX_NEIGHBOURS = 40,
   parameter int MAX_LOCATIONS  = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_type                    rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   logic [LOC_WIDTH-1:0] depot_count_ff;
   logic [CNT_WIDTH-1:0] neighbour_count_ff;

   logic          req_accept;
   logic          is_cand;
   logic          depot_row;
   logic          pop;
   entry_type     cand;
   drain_ctl_type drain_ctl;

   entry_type list_ent  [MAX_NEIGHBOURS];
   entry_type list_nxt  [MAX_NEIGHBOURS];
   logic      list_eff  [MAX_NEIGHBOURS];
   entry_type left_ent  [MAX_NEIGHBOURS];
   logic      left_eff  [MAX_NEIGHBOURS];
   entry_type drain_ent [MAX_NEIGHBOURS+1];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         depot_count_ff     <= DEPOT_COUNT_RESET;
         neighbour_count_ff <= NEIGHBOUR_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEPOT_COUNT: begin
               depot_count_ff <= csr_data;
            end
            CSR_NEIGHBOUR_COUNT: begin
               neighbour_count_ff <= csr_data[CNT_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // a row end must wait until the previous row has drained
   assign req_ready  = !drain_ent[0].valid || !req_data.last_in_row;
   assign req_accept = req_valid && req_ready;

   assign is_cand = (req_data.column_location >= depot_count_ff)
                 && ({22'b0, req_data.column_location} < 32'(MAX_LOCATIONS))
                 && (req_data.column_location != req_data.row_location);
   assign depot_row = req_data.row_location < depot_count_ff;

   assign cand = '{valid: 1'b1, distance: req_data.distance,
                   location: req_data.column_location};

   assign drain_ctl.load = req_accept && req_data.last_in_row;
   assign drain_ctl.pop  = pop;

   assign drain_ent[MAX_NEIGHBOURS] = ENTRY_EMPTY;

   for (genvar i = 0; i < MAX_NEIGHBOURS; i++) begin : g_cell
      list_ctl_type list_ctl;
      entry_type    load_ent;

      assign list_ctl.insert = req_accept && is_cand && (neighbour_count_ff != '0);
      assign list_ctl.clear  = req_accept && req_data.last_in_row;
      assign list_ctl.in_cap = 7'(i) < {1'b0, neighbour_count_ff};

      if (i == 0) begin : g_head
         assign left_ent[i] = ENTRY_EMPTY;
         assign left_eff[i] = 1'b0;
      end else begin : g_body
         assign left_ent[i] = list_ent[i-1];
         assign left_eff[i] = list_eff[i-1];
      end

      knn_list_cell u_list (
         .clock    (clock),
         .reset    (reset),
         .ctl      (list_ctl),
         .cand     (cand),
         .left_ent (left_ent[i]),
         .left_eff (left_eff[i]),
         .ent      (list_ent[i]),
         .eff      (list_eff[i]),
         .nxt      (list_nxt[i])
      );

      // slots beyond capacity and depot rows are not emitted
      always_comb begin
         load_ent       = list_nxt[i];
         load_ent.valid = list_nxt[i].valid && list_ctl.in_cap && !depot_row;
      end

      knn_drain_cell u_drain (
         .clock     (clock),
         .reset     (reset),
         .ctl       (drain_ctl),
         .load_ent  (load_ent),
         .right_ent (drain_ent[i+1]),
         .ent       (drain_ent[i])
      );
   end

   assign rsp_valid = drain_ent[0].valid;
   assign pop       = rsp_valid && rsp_ready;

   assign rsp_data.neighbour_location = drain_ent[0].location;
   assign rsp_data.neighbour_distance = drain_ent[0].distance;
   assign rsp_data.last_neighbour     = !drain_ent[1].valid;

   // drain chain stays packed toward the head
   a_drain_packed: assert property (@(posedge clock) disable iff (reset)
      drain_ent[1].valid |-> drain_ent[0].valid)
      else $error("drain chain has a gap at the head");

   // list slots stay packed toward the head
   a_list_packed: assert property (@(posedge clock) disable iff (reset)
      list_ent[MAX_NEIGHBOURS-1].valid |-> list_ent[0].valid)
      else $error("list holds an entry behind an empty head");

   // a row end leaves the list empty
   a_list_cleared: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.last_in_row) |=> !list_ent[0].valid)
      else $error("list not cleared after row end");

   // a depot row emits nothing
   a_depot_silent: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.last_in_row && depot_row) |=> !rsp_valid)
      else $error("depot row produced a result");

   // back-pressure only while results are pending
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled with no result pending");

endmodule

FILE: sv/knn_list_cell.sv
// knn_list_cell: one slot of the sorted neighbour list. Compares the broadcast
// candidate with its own entry and takes the candidate, its left neighbor's entry, or keeps its own.
// Depends on knn_pkg.
module knn_list_cell import knn_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  list_ctl_type ctl,
   input  entry_type    cand,
   input  entry_type    left_ent,
   input  logic         left_eff,
   output entry_type    ent,
   output logic         eff,
   output entry_type    nxt
);

   logic                  valid_ff;
   logic [DIST_WIDTH-1:0] distance_ff;
   logic [LOC_WIDTH-1:0]  location_ff;
   logic                  valid_in;

   assign ent = '{valid: valid_ff, distance: distance_ff, location: location_ff};

   // candidate belongs here or earlier
   assign eff = !valid_ff
             || orders_first(cand.distance, cand.location, distance_ff, location_ff);

   always_comb begin
      nxt = ent;
      if (ctl.insert) begin
         if (!ctl.in_cap) begin
            nxt.valid = 1'b0;
         end else if (left_eff) begin
            nxt = left_ent;
         end else if (eff) begin
            nxt = cand;
         end
      end
      valid_in = nxt.valid && !ctl.clear;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      distance_ff <= nxt.distance;
      location_ff <= nxt.location;
   end

endmodule

FILE: sv/knn_drain_cell.sv
// knn_drain_cell: one stage of the result shift chain. Loaded in parallel
// from the list at row end, then shifts toward the head one result per pop.
// Depends on knn_pkg.
module knn_drain_cell import knn_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  drain_ctl_type ctl,
   input  entry_type     load_ent,
   input  entry_type     right_ent,
   output entry_type     ent
);

   logic                  valid_ff;
   logic [DIST_WIDTH-1:0] distance_ff;
   logic [LOC_WIDTH-1:0]  location_ff;
   entry_type             ent_in;

   assign ent = '{valid: valid_ff, distance: distance_ff, location: location_ff};

   always_comb begin
      ent_in = ent;
      if (ctl.load) begin
         ent_in = load_ent;
      end else if (ctl.pop) begin
         ent_in = right_ent;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ent_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      distance_ff <= ent_in.distance;
      location_ff <= ent_in.location;
   end

endmodule

FILE: test/tb_k_nearest_neighbour_select_top.sv
// tb_k_nearest_neighbour_select_top: self-checking bench for the k-nearest-neighbour
// selection block, with a scoreboard class that keeps its own sorted neighbour list.
// Depends on knn_pkg and k_nearest_neighbour_select_top.
module tb_k_nearest_neighbour_select_top import knn_pkg::*; ;

   localparam int MAX_KEPT    = 40;
   localparam int TOTAL_ITEMS = 360;
   localparam int SETTLE      = 8;
   localparam int LONG_HOLD   = 400;
   localparam int CYCLE_LIMIT = 300000;

   class neighbour_checker;
      logic [DIST_WIDTH-1:0] kept_distance [MAX_KEPT];
      logic [LOC_WIDTH-1:0]  kept_location [MAX_KEPT];
      int                    kept_total;
      logic [LOC_WIDTH-1:0]  depot_count;
      logic [CNT_WIDTH-1:0]  neighbour_count;
      rsp_type               expected_neighbours [$];
      int                    errors;
      int                    rows_closed;
      int                    neighbours_checked;
      int                    register_writes;

      function new();
         depot_count        = DEPOT_COUNT_RESET;
         neighbour_count    = NEIGHBOUR_COUNT_RESET;
         errors             = 0;
         rows_closed        = 0;
         neighbours_checked = 0;
         register_writes    = 0;
         clear_list();
      endfunction

      function void clear_list();
         for (int i = 0; i < MAX_KEPT; i++) begin
            kept_distance[i] = '1;
            kept_location[i] = '0;
         end
         kept_total = 0;
      endfunction

      function int capacity();
         return (neighbour_count > MAX_KEPT) ? MAX_KEPT : int'(neighbour_count);
      endfunction

      function bit precedes(input logic [DIST_WIDTH-1:0] d1, input logic [LOC_WIDTH-1:0] l1,
                            input logic [DIST_WIDTH-1:0] d2, input logic [LOC_WIDTH-1:0] l2);
         return (d1 < d2) || ((d1 == d2) && (l1 < l2));
      endfunction

      function void insert_candidate(input logic [DIST_WIDTH-1:0] cand_distance,
                                     input logic [LOC_WIDTH-1:0] loc);
         int k;
         int n;
         int pos;
         k = capacity();
         n = (kept_total < k) ? kept_total : k;
         if (k == 0) return;
         if (n == k) begin
            // full list: the candidate must beat the worst kept entry
            if (!precedes(cand_distance, loc, kept_distance[n-1], kept_location[n-1])) begin
               kept_total = n;
               return;
            end
            n = n - 1;
         end
         pos = n;
         while (pos > 0 && precedes(cand_distance, loc, kept_distance[pos-1],
                                    kept_location[pos-1])) begin
            kept_distance[pos] = kept_distance[pos-1];
            kept_location[pos] = kept_location[pos-1];
            pos--;
         end
         kept_distance[pos] = cand_distance;
         kept_location[pos] = loc;
         kept_total = n + 1;
      endfunction

      function void write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                   input logic [CSR_DATA_WIDTH-1:0] value);
         case (index)
            CSR_DEPOT_COUNT:     depot_count = value[LOC_WIDTH-1:0];
            CSR_NEIGHBOUR_COUNT: neighbour_count = value[CNT_WIDTH-1:0];
            default: ;
         endcase
         register_writes++;
      endfunction

      function void note_request(input req_type item);
         int k;
         int n;
         rsp_type neighbour;
         if (item.column_location >= depot_count && item.column_location != item.row_location)
            insert_candidate(item.distance, item.column_location);
         if (!item.last_in_row) return;
         rows_closed++;
         k = capacity();
         n = (kept_total < k) ? kept_total : k;
         // depot rows are still cleared but emit nothing
         if (item.row_location < depot_count) n = 0;
         for (int i = 0; i < n; i++) begin
            neighbour.neighbour_location = kept_location[i];
            neighbour.neighbour_distance = kept_distance[i];
            neighbour.last_neighbour     = (i == n - 1);
            expected_neighbours = {expected_neighbours, neighbour};
         end
         clear_list();
      endfunction

      function void check_result(input rsp_type got);
         rsp_type want;
         if (expected_neighbours.size() == 0) begin
            $error("unexpected neighbour: location %0d distance %0d last %0b",
                   got.neighbour_location, got.neighbour_distance, got.last_neighbour);
            errors++;
            return;
         end
         want = expected_neighbours.pop_front();
         neighbours_checked++;
         if (got.neighbour_location !== want.neighbour_location) begin
            $error("neighbour_location: expected %0d, actual %0d",
                   want.neighbour_location, got.neighbour_location);
            errors++;
         end
         if (got.neighbour_distance !== want.neighbour_distance) begin
            $error("neighbour_distance: expected %0d, actual %0d",
                   want.neighbour_distance, got.neighbour_distance);
            errors++;
         end
         if (got.last_neighbour !== want.last_neighbour) begin
            $error("last_neighbour: expected %0b, actual %0b",
                   want.last_neighbour, got.last_neighbour);
            errors++;
         end
      endfunction

      function int pending();
         return expected_neighbours.size();
      endfunction
   endclass

   logic                       clock;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   req_type                    req_data  = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   rsp_type                    rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data  = '0;

   neighbour_checker sb = new();

   int cycle_count   = 0;
   int items_sent    = 0;
   int send_calm     = 0;
   int recv_calm     = 0;
   int cur_depot     = 1;
   bit hold_receiver = 1'b0;

   k_nearest_neighbour_select_top #(
      .MAX_NEIGHBOURS(MAX_KEPT),
      .MAX_LOCATIONS (1024)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // handshakes are sampled at the edge, before any update of that edge lands
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_register(csr_index, csr_data);
         if (req_valid && req_ready) sb.note_request(req_data);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   // random idle wait, with occasional runs of back-to-back traffic
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) calm = $urandom_range(8, 30);
      return $urandom_range(0, 12);
   endfunction

   initial begin
      int w;
      forever begin
         w = draw_wait(recv_calm);
         if (hold_receiver) begin
            hold_receiver = 1'b0;
            w = LONG_HOLD;
         end
         if (w > 0) begin
            rsp_ready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   task automatic send_request(input req_type item);
      int gap;
      gap = draw_wait(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic send_entry(input int row, input int col,
                             input logic [DIST_WIDTH-1:0] distance_value, input bit last);
      req_type item;
      item.row_location    = LOC_WIDTH'(row);
      item.column_location = LOC_WIDTH'(col);
      item.distance        = distance_value;
      item.last_in_row     = last;
      send_request(item);
   endtask

   task automatic configure(input int depot, input int count);
      csr_valid <= 1'b1;
      csr_index <= CSR_DEPOT_COUNT;
      csr_data  <= CSR_DATA_WIDTH'(depot);
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_NEIGHBOUR_COUNT;
      csr_data  <= CSR_DATA_WIDTH'(count);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_depot = depot & 10'h3FF;
   endtask

   // lets every pending neighbour drain, then lets the insertion pipe settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [LOC_WIDTH-1:0] pick_column(input int row);
      case ($urandom_range(0, 9))
         0:       return LOC_WIDTH'(row);
         1:       return (cur_depot > 0) ? LOC_WIDTH'($urandom_range(0, cur_depot - 1)) : '0;
         2:       return LOC_WIDTH'(cur_depot);
         3:       return '1;
         default: return LOC_WIDTH'($urandom_range(0, 1023));
      endcase
   endfunction

   function automatic logic [DIST_WIDTH-1:0] pick_distance();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2, 3:    return DIST_WIDTH'($urandom_range(0, 7));
         4:       return DIST_WIDTH'($urandom_range(0, 1000));
         default: return DIST_WIDTH'($urandom);
      endcase
   endfunction

   // one row of matrix entries; noisy rows may switch row index, mark early or never close
   task automatic send_random_row(input int len, input bit clean);
      int row;
      bit broken;
      bit noise;
      req_type item;
      row = ($urandom_range(0, 9) != 0) ? $urandom_range(cur_depot, 1023)
                                        : $urandom_range(0, 1023);
      broken = !clean && ($urandom_range(0, 9) == 0);
      for (int i = 0; i < len; i++) begin
         noise = !clean && ($urandom_range(0, 11) == 0);
         item.row_location    = noise ? LOC_WIDTH'($urandom_range(0, 1023)) : LOC_WIDTH'(row);
         item.column_location = pick_column(row);
         item.distance        = pick_distance();
         if (i == len - 1) item.last_in_row = !broken;
         else              item.last_in_row = noise && ($urandom_range(0, 1) == 1);
         send_request(item);
      end
   endtask

   initial begin
      int phase;
      int phase_end;
      int depot;
      int count;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // depot column, self column, extreme distances, a tie and a repeated column
      send_entry(5, 0, 32'd10, 1'b0);
      send_entry(5, 5, 32'd0, 1'b0);
      send_entry(5, 1023, 32'd0, 1'b0);
      send_entry(5, 7, 32'd100, 1'b0);
      send_entry(5, 3, 32'd100, 1'b0);
      send_entry(5, 7, 32'd50, 1'b0);
      send_entry(5, 1, 32'hFFFF_FFFF, 1'b1);
      // depot row, a row with no candidates, a row index that changes mid-row
      send_entry(0, 2, 32'd1, 1'b1);
      send_entry(1023, 0, 32'd0, 1'b1);
      send_entry(0, 4, 32'd5, 1'b0);
      send_entry(3, 2, 32'd9, 1'b1);
      wait_idle();
      configure(0, 0);
      send_entry(0, 1, 32'd3, 1'b1);
      wait_idle();
      // capacity above the list size saturates
      configure(0, 63);
      send_entry(1, 0, 32'd7, 1'b0);
      send_entry(1, 2, 32'd7, 1'b1);
      wait_idle();
      configure(1023, 1);
      send_entry(1023, 1022, 32'd4, 1'b0);
      send_entry(1022, 1023, 32'd4, 1'b1);
      wait_idle();
      configure(1, 3);
      send_entry(9, 2, 32'd30, 1'b0);
      send_entry(9, 4, 32'd20, 1'b0);
      send_entry(9, 6, 32'd10, 1'b0);
      wait_idle();
      // capacity lowered while the row is still open
      configure(1, 1);
      send_entry(9, 8, 32'd25, 1'b0);
      send_entry(9, 10, 32'd5, 1'b1);
      wait_idle();
      // upper data bits of the capacity write are dropped
      configure(2, 10'h3C2);
      send_entry(700, 1023, 32'hFFFF_FFFF, 1'b0);
      send_entry(700, 512, 32'hFFFF_FFFE, 1'b1);

      phase = 0;
      while (items_sent < TOTAL_ITEMS) begin
         wait_idle();
         if (phase == 3) begin
            // receiver stalls long while full rows arrive back to back
            configure(1, 40);
            hold_receiver = 1'b1;
            send_calm = 150;
            repeat (2) send_random_row(42, 1'b1);
         end else begin
            case ($urandom_range(0, 5))
               0:       depot = 0;
               2, 3:    depot = $urandom_range(2, 16);
               4:       depot = $urandom_range(0, 600);
               default: depot = 1;
            endcase
            case ($urandom_range(0, 7))
               0:       count = 0;
               1:       count = 40;
               2:       count = 1;
               3:       count = $urandom_range(41, 63);
               4:       count = $urandom_range(0, 1023);
               default: count = $urandom_range(1, 40);
            endcase
            configure(depot, count);
            phase_end = items_sent + $urandom_range(15, 45);
            while (items_sent < phase_end)
               send_random_row(($urandom_range(0, 7) == 0) ? $urandom_range(13, 60)
                                                          : $urandom_range(1, 12), 1'b0);
         end
         phase++;
      end
      wait_idle();

      $display("covered %0d matrix entries, %0d row ends and %0d neighbours checked",
               items_sent, sb.rows_closed, sb.neighbours_checked);
      $display("%0d register writes over %0d configurations, one long receiver stall",
               sb.register_writes, phase + 6);
      if (sb.errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

FILE: sim.f
sv/knn_pkg.sv
sv/knn_list_cell.sv
sv/knn_drain_cell.sv
sv/k_nearest_neighbour_select_top.sv
test/tb_k_nearest_neighbour_select_top.sv
